// ===== rtl/core/prle_pkg.sv =====
// shared types and constants of the palette run-length encoder
package prle_pkg;

    // default palette size
    localparam int PRLE_DEPTH_DEF = 256;

    // longest run that one result can carry
    localparam logic [15:0] MAX_RUN = 16'hFFFF;

    // colour that a transparent pixel is replaced by
    localparam logic [31:0] ZERO_COLOR = 32'h0000_0000;

    // number of result slots in the output queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // item kinds carried on the input tuser bit
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // one input item as it travels along the cell chain
    typedef struct packed {
        logic        cmd;
        logic [7:0]  slot;
        logic [31:0] color;
        logic        frame_end;
    } t_item;

    // one emitted run
    typedef struct packed {
        logic        frame_done;
        logic [15:0] run_length;
        logic [7:0]  run_index;
    } t_run;

    // up to two runs handed to the output queue in one cycle, in order a then b
    typedef struct packed {
        logic push_a;
        logic push_b;
        t_run run_a;
        t_run run_b;
    } t_push;

endpackage

// ===== rtl/core/palette_run_length_encoder.sv =====
// palette run-length encoder top level: cell chain, run builder and output queue
//
// Input stream (s_axis): tuser selects the item kind, 0 loads a palette slot,
// 1 encodes a pixel; tlast marks the last pixel of a frame. Loads and pixels
// share one stream and are served strictly in order, so a pixel sees every
// load that was transferred before it.
// Output stream (m_axis): one (palette index, run length) pair per transfer,
// tlast set on the final run of a frame. A pixel may close one run and end a
// frame, giving two transfers.
// The transparent colour is written through i_cfg_we / i_cfg_wdata; the user
// must do so only while idle, the block does not enforce it. Each item walks
// the PALETTE_DEPTH cells in order, and closed runs pass to the output queue.
// Throughput: one item per cycle; the chain moves as a whole and only halts
// while a pixel sits at its end and the four-deep output queue holds more
// than two runs, as when runs arrive faster than the receiver takes them.
// Reset empties the chain and the queue, forgets all palette slots, closes
// the open run and sets the transparent colour to zero.
module palette_run_length_encoder #(
    parameter int PALETTE_DEPTH = prle_pkg::PRLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // entry_index [7:0], color [39:8], zero [47:40]
    input  logic        s_axis_tuser,   // cmd
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // run_index [7:0], run_length [23:8]
    output logic        m_axis_tlast
);
    import prle_pkg::*;

    localparam int IDX_W = $clog2(PALETTE_DEPTH);

    logic             w_transparent;
    logic [31:0]      r_trans_color;
    logic             w_adv;
    logic             w_room2;
    t_item            w_in_item;
    t_push            w_push;
    t_run             w_out_run;

    logic             w_vld   [PALETTE_DEPTH + 1];
    t_item            w_item  [PALETTE_DEPTH + 1];
    logic             w_found [PALETTE_DEPTH + 1];
    logic [IDX_W-1:0] w_idx   [PALETTE_DEPTH + 1];

    // transparent colour register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_color <= ZERO_COLOR;
        end else if (i_cfg_we) begin
            r_trans_color <= i_cfg_wdata;
        end
    end

    // transparent pixels become colour zero before the search
    assign w_transparent = (s_axis_tuser == CMD_PIXEL) && (s_axis_tdata[39:8] == r_trans_color);
    always_comb begin
        w_in_item.cmd       = s_axis_tuser;
        w_in_item.slot      = s_axis_tdata[7:0];
        w_in_item.color     = w_transparent ? ZERO_COLOR : s_axis_tdata[39:8];
        w_in_item.frame_end = s_axis_tlast;
    end

    // the chain halts only for a pixel whose runs may not fit
    assign w_adv = !(w_vld[PALETTE_DEPTH] && (w_item[PALETTE_DEPTH].cmd == CMD_PIXEL) &&
                     !w_room2);
    assign s_axis_tready = w_adv;

    assign w_vld[0]   = s_axis_tvalid;
    assign w_item[0]  = w_in_item;
    assign w_found[0] = 1'b0;
    assign w_idx[0]   = '0;

    // search chain, one palette slot per cell
    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        prle_cell #(
            .CELL_ID (g),
            .IDX_W   (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (w_vld[g]),
            .i_item  (w_item[g]),
            .i_found (w_found[g]),
            .i_idx   (w_idx[g]),
            .o_vld   (w_vld[g + 1]),
            .o_item  (w_item[g + 1]),
            .o_found (w_found[g + 1]),
            .o_idx   (w_idx[g + 1])
        );
    end

    // run building at the chain end
    prle_run #(
        .IDX_W (IDX_W)
    ) u_run (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_vld[PALETTE_DEPTH]),
        .i_item  (w_item[PALETTE_DEPTH]),
        .i_found (w_found[PALETTE_DEPTH]),
        .i_idx   (w_idx[PALETTE_DEPTH]),
        .o_push  (w_push)
    );

    // output queue
    prle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room2 (w_room2),
        .o_vld   (m_axis_tvalid),
        .o_run   (w_out_run),
        .i_rdy   (m_axis_tready)
    );

    assign m_axis_tdata = {w_out_run.run_length, w_out_run.run_index};
    assign m_axis_tlast = w_out_run.frame_done;

`ifndef SYNTH
    // nothing is offered in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output offered after reset");

    // every offered run holds at least one pixel
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:8] != 16'd0))
        else $error("empty run offered");

    // a halted chain keeps its waiting pixel at the end
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[PALETTE_DEPTH] && !w_adv) |=> w_vld[PALETTE_DEPTH])
        else $error("pixel lost while chain halted");

    // the queue never takes two runs without room for them
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push_b |-> (w_push.push_a && w_room2))
        else $error("output queue overrun");
`endif

endmodule

// ===== rtl/core/prle_cell.sv =====
// one palette slot of the search chain: holds a colour and matches passing pixels
module prle_cell #(
    parameter int CELL_ID = 0,
    parameter int IDX_W   = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  prle_pkg::t_item  i_item,
    input  logic             i_found,
    input  logic [IDX_W-1:0] i_idx,
    output logic             o_vld,
    output prle_pkg::t_item  o_item,
    output logic             o_found,
    output logic [IDX_W-1:0] o_idx
);
    import prle_pkg::*;

    logic             r_vld;
    logic             r_entry_vld;
    logic [31:0]      r_entry;
    t_item            r_item;
    logic             r_found;
    logic [IDX_W-1:0] r_idx;

    logic w_load_hit;
    logic w_match;

    // load aimed at this slot, or first pixel match along the chain
    assign w_load_hit = i_vld && (i_item.cmd == CMD_LOAD) && (32'(i_item.slot) == 32'(CELL_ID));
    assign w_match    = i_vld && (i_item.cmd == CMD_PIXEL) && !i_found && r_entry_vld &&
                        (r_entry == i_item.color);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= 1'b0;
            r_entry_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
            if (w_load_hit) begin
                r_entry_vld <= 1'b1;
            end
        end
    end

    // slot colour and item payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (w_load_hit) begin
                r_entry <= i_item.color;
            end
            r_item  <= i_item;
            r_found <= i_found || w_match;
            r_idx   <= w_match ? IDX_W'(CELL_ID) : i_idx;
        end
    end

    assign o_vld   = r_vld;
    assign o_item  = r_item;
    assign o_found = r_found;
    assign o_idx   = r_idx;

endmodule

// ===== rtl/core/prle_run.sv =====
// run builder: gathers looked-up indices into runs and closes them
module prle_run #(
    parameter int IDX_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  prle_pkg::t_item  i_item,
    input  logic             i_found,
    input  logic [IDX_W-1:0] i_idx,
    output prle_pkg::t_push  o_push
);
    import prle_pkg::*;

    logic        r_open;
    logic [7:0]  r_cur_idx;
    logic [15:0] r_cur_cnt;
    logic        n_open;
    logic [7:0]  n_cur_idx;
    logic [15:0] n_cur_cnt;

    logic        w_pix;
    logic [7:0]  w_idx8;
    logic        w_join;
    logic        w_close;
    t_run        w_closed;
    t_run        w_final;

    // pixel index, missing colours take index zero
    assign w_pix  = i_adv && i_vld && (i_item.cmd == CMD_PIXEL);
    assign w_idx8 = i_found ? 8'(i_idx) : 8'd0;
    assign w_join = r_open && (w_idx8 == r_cur_idx) && (r_cur_cnt != MAX_RUN);
    assign w_close = r_open && !w_join;

    // next run state and emitted runs
    always_comb begin
        n_open    = r_open;
        n_cur_idx = r_cur_idx;
        n_cur_cnt = r_cur_cnt;
        if (w_pix) begin
            if (w_join) begin
                n_cur_cnt = r_cur_cnt + 16'd1;
            end else begin
                n_cur_idx = w_idx8;
                n_cur_cnt = 16'd1;
            end
            n_open = 1'b1;
        end

        w_closed.run_index  = r_cur_idx;
        w_closed.run_length = r_cur_cnt;
        w_closed.frame_done = 1'b0;
        w_final.run_index   = n_cur_idx;
        w_final.run_length  = n_cur_cnt;
        w_final.frame_done  = 1'b1;

        o_push.push_a = 1'b0;
        o_push.push_b = 1'b0;
        o_push.run_a  = w_closed;
        o_push.run_b  = w_final;
        if (w_pix) begin
            if (w_close) begin
                o_push.push_a = 1'b1;
                o_push.push_b = i_item.frame_end;
            end else begin
                o_push.push_a = i_item.frame_end;
                o_push.run_a  = w_final;
            end
            if (i_item.frame_end) begin
                n_open    = 1'b0;
                n_cur_cnt = 16'd0;
            end
        end
    end

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_cur_idx <= 8'd0;
            r_cur_cnt <= 16'd0;
        end else begin
            r_open    <= n_open;
            r_cur_idx <= n_cur_idx;
            r_cur_cnt <= n_cur_cnt;
        end
    end

endmodule

// ===== rtl/core/prle_fifo.sv =====
// small output queue taking up to two runs per cycle and giving one while the receiver is ready
module prle_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  prle_pkg::t_push i_push,
    output logic            o_room2,
    output logic            o_vld,
    output prle_pkg::t_run  o_run,
    input  logic            i_rdy
);
    import prle_pkg::*;

    t_run                 r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr;
    logic [OUT_PTR_W-1:0] r_rd;
    logic [OUT_CNT_W-1:0] r_cnt;
    logic [OUT_PTR_W-1:0] n_wr;
    logic [OUT_CNT_W-1:0] n_cnt;
    logic                 w_pop;
    logic [1:0]           w_npush;

    assign w_pop   = o_vld && i_rdy;
    assign w_npush = {1'b0, i_push.push_a} + {1'b0, i_push.push_b};
    assign n_wr    = r_wr + OUT_PTR_W'(w_npush);
    assign n_cnt   = r_cnt + OUT_CNT_W'(w_npush) - OUT_CNT_W'(w_pop);

    assign o_room2 = (r_cnt <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign o_vld   = (r_cnt != '0);
    assign o_run   = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
            if (w_pop) begin
                r_rd <= r_rd + OUT_PTR_W'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push.push_a) begin
            r_mem[r_wr] <= i_push.run_a;
        end
        if (i_push.push_b) begin
            r_mem[r_wr + OUT_PTR_W'(1)] <= i_push.run_b;
        end
    end

endmodule
